[rtl/core/serial_frame_decoder_crc16_assert.svh]
// Assertion macros for the serial frame decoder.
// Used by the top level; relies on i_clk and i_rst_n in the including scope.
`ifndef SERIAL_FRAME_DECODER_CRC16_ASSERT_SVH
`define SERIAL_FRAME_DECODER_CRC16_ASSERT_SVH

// same-cycle implication
`define SFD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfd assertion failed");

// next-cycle implication
`define SFD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfd assertion failed");

`endif

[rtl/core/sfd_pkg.sv]
// Shared constants, types and helper functions of the serial frame decoder.
// No dependencies.
package sfd_pkg;

    localparam int MAX_FRAME_BYTES         = 1024;
    localparam int PRE_HANDSHAKE_BYTES     = 256;
    localparam int NEGOTIATED_PACKET_BYTES = 960;
    localparam int FRAME_OVERHEAD_BYTES    = 64;
    localparam int MAX_PAYLOAD_FIELDS      = 16;

    localparam int FIELD_CAP = 2 + MAX_PAYLOAD_FIELDS;
    localparam int ADDR_W    = $clog2(MAX_FRAME_BYTES);
    localparam int CNT_W     = $clog2(MAX_FRAME_BYTES + 1);
    localparam int FCNT_W    = $clog2(FIELD_CAP + 1);
    localparam int PKT_W     = $clog2(NEGOTIATED_PACKET_BYTES + 1);
    localparam int LIM_W     = $clog2(NEGOTIATED_PACKET_BYTES + FRAME_OVERHEAD_BYTES + 1);
    localparam int LEN_W     = 11;
    localparam int FC_W      = 5;

    localparam logic [CNT_W-1:0] LIMIT_RST =
        CNT_W'((PRE_HANDSHAKE_BYTES < MAX_FRAME_BYTES) ? PRE_HANDSHAKE_BYTES
                                                        : MAX_FRAME_BYTES);

    localparam logic       OP_PUSH = 1'b0;
    localparam logic       OP_END  = 1'b1;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_BAR   = 8'h7c;
    localparam logic [7:0] CH_K     = 8'h4b;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7e;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int LEAD_LEN   = 3;
    localparam int MIN_FRAME  = 9;
    localparam int CRC_DIGITS = 4;
    localparam int MODEL_LEN  = 7;
    localparam int VENDOR_LEN = 14;
    localparam int F4_LEN     = 10;
    localparam int REQ_FIELDS = 12;
    localparam int SEQ_FIELDS = 7;
    localparam int FN_MAX     = 192;

    localparam logic [31:0] TYPE_REQ   = 32'd2;
    localparam logic [31:0] TYPE_SEQ_A = 32'd6;
    localparam logic [31:0] TYPE_SEQ_B = 32'd8;
    localparam logic [31:0] TYPE_SEQ_C = 32'd32;

    localparam logic [FCNT_W-1:0] F_TYPE    = FCNT_W'(0);
    localparam logic [FCNT_W-1:0] F_ELAPSED = FCNT_W'(1);
    localparam logic [FCNT_W-1:0] F_PLAT    = FCNT_W'(2);
    localparam logic [FCNT_W-1:0] F_CAPS    = FCNT_W'(3);
    localparam logic [FCNT_W-1:0] F_IDENT   = FCNT_W'(4);
    localparam logic [FCNT_W-1:0] F_VER     = FCNT_W'(5);
    localparam logic [FCNT_W-1:0] F_MODEL   = FCNT_W'(6);
    localparam logic [FCNT_W-1:0] F_VENDOR  = FCNT_W'(7);
    localparam logic [FCNT_W-1:0] F_PKT     = FCNT_W'(9);
    localparam logic [FCNT_W-1:0] F_FN      = FCNT_W'(10);
    localparam logic [FCNT_W-1:0] F_SEED    = FCNT_W'(11);

    typedef enum logic [2:0] {
        K_NONE       = 3'd0,
        K_FRAME      = 3'd1,
        K_MALFORMED  = 3'd2,
        K_CRC_FAILED = 3'd3,
        K_TOO_LARGE  = 3'd4,
        K_TRUNCATED  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_CRC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic take;
        logic scan_start;
        logic walk_scan;
        logic crc_start;
        logic walk_crc;
        logic fin_load;
    } t_cmd;

    typedef struct packed {
        logic need_decode;
        logic out_free;
        logic walk_done;
        logic struct_ok;
    } t_sts;

    function automatic logic [7:0] lead_chr(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h4b;
            2'd1:    ch = 8'h4c;
            2'd2:    ch = 8'h2a;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] model_chr(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h4b;
            3'd1:    ch = 8'h4e;
            3'd2:    ch = 8'h31;
            3'd3:    ch = 8'h30;
            3'd4:    ch = 8'h30;
            3'd5:    ch = 8'h37;
            3'd6:    ch = 8'h42;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] vendor_chr(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h6b;
            4'd1:    ch = 8'h61;
            4'd2:    ch = 8'h66;
            4'd3:    ch = 8'h66;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6c;
            4'd6:    ch = 8'h6f;
            4'd7:    ch = 8'h67;
            4'd8:    ch = 8'h69;
            4'd9:    ch = 8'h63;
            4'd10:   ch = 8'h2e;
            4'd11:   ch = 8'h63;
            4'd12:   ch = 8'h6f;
            4'd13:   ch = 8'h6d;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/core/serial_frame_decoder_crc16.sv]
// Top level of the serial frame decoder with CRC-16 frame check.
// Depends on sfd_pkg, sfd_ctrl, sfd_dp and the assertion macro header.
//
// Input channel: i_in_valid / o_in_stall with i_opcode (0 push byte, 1 end of
// stream) and i_data_byte. Output channel: o_out_valid / i_out_stall with one
// result item for every input item, in input order.
// A byte that does not end a frame has its result in the output register the
// cycle after it is accepted, and while the output is not stalled the next
// byte is taken in that same cycle, so plain bytes flow at one per cycle.
// A carriage return that ends a frame of N stored bytes (prefix included)
// starts two walks over the frame RAM through its single read port: a field
// scan of N-3 bytes and, for a well-formed frame, a CRC pass of S+1 bytes,
// S being the position of the last '|'. No input is taken until the result
// is loaded into the output register.
// Reset is synchronous: control and stream state clear at once, the frame RAM
// is left as is and needs no clearing pass.
// A stalled output holds its item; the block then takes nothing new until
// the output register is free again.
module serial_frame_decoder_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_kind,
    output logic [31:0] o_frame_type,
    output logic [63:0] o_elapsed_time,
    output logic [15:0] o_crc_seed_used,
    output logic [4:0]  o_payload_fields,
    output logic [10:0] o_frame_length,
    output logic        o_is_connection_request,
    output logic        o_conn_accepted,
    output logic        o_seq_valid,
    output logic [31:0] o_sequence_number
);

`include "serial_frame_decoder_crc16_assert.svh"

    sfd_pkg::t_cmd cmd;
    sfd_pkg::t_sts sts;

    sfd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_sts     (sts),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd)
    );

    sfd_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_opcode               (i_opcode),
        .i_data_byte            (i_data_byte),
        .i_out_stall            (i_out_stall),
        .i_cmd                  (cmd),
        .o_sts                  (sts),
        .o_out_valid            (o_out_valid),
        .o_event_kind           (o_event_kind),
        .o_frame_type           (o_frame_type),
        .o_elapsed_time         (o_elapsed_time),
        .o_crc_seed_used        (o_crc_seed_used),
        .o_payload_fields       (o_payload_fields),
        .o_frame_length         (o_frame_length),
        .o_is_connection_request(o_is_connection_request),
        .o_conn_accepted        (o_conn_accepted),
        .o_seq_valid            (o_seq_valid),
        .o_sequence_number      (o_sequence_number)
    );

    `SFD_ASSERT_IMPL(a_take_not_walking, cmd.take, !cmd.walk_scan && !cmd.walk_crc)
    `SFD_ASSERT_NEXT(a_fin_gives_item, cmd.fin_load, o_out_valid)
    `SFD_ASSERT_IMPL(a_non_frame_zero,
        o_out_valid && o_event_kind != sfd_pkg::K_FRAME,
        o_frame_type == 32'd0 && o_payload_fields == 5'd0 && o_frame_length == 11'd0)
    `SFD_ASSERT_IMPL(a_seq_zero, o_out_valid && !o_seq_valid, o_sequence_number == 32'd0)

endmodule

[rtl/core/sfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

[rtl/core/sfd_dp.sv]
// Datapath of the serial frame decoder: stream state, frame RAM, field scanner,
// CRC unit and output register. Depends on sfd_pkg and sfd_ram.
module sfd_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_opcode,
    input  logic [7:0]          i_data_byte,
    input  logic                i_out_stall,
    input  sfd_pkg::t_cmd       i_cmd,
    output sfd_pkg::t_sts       o_sts,
    output logic                o_out_valid,
    output logic [2:0]          o_event_kind,
    output logic [31:0]         o_frame_type,
    output logic [63:0]         o_elapsed_time,
    output logic [15:0]         o_crc_seed_used,
    output logic [4:0]          o_payload_fields,
    output logic [10:0]         o_frame_length,
    output logic                o_is_connection_request,
    output logic                o_conn_accepted,
    output logic                o_seq_valid,
    output logic [31:0]         o_sequence_number
);

    localparam int CW = sfd_pkg::CNT_W;
    localparam int FW = sfd_pkg::FCNT_W;

    // stream state
    logic [CW-1:0] r_count, n_count;
    logic          r_in_frame, n_in_frame;
    logic          r_discard, n_discard;
    logic [1:0]    r_prefix, n_prefix;
    logic          r_hs;
    logic [15:0]   r_sess_seed;
    logic [CW-1:0] r_limit;

    sfd_pkg::t_kind step_kind;
    logic           ram_we;
    logic           need_decode;
    logic           over;
    logic [CW:0]    count_p2;

    // walker
    logic [CW-1:0] r_ptr, r_end, r_pend_idx;
    logic          r_pend, r_mode_crc;
    logic          issue;
    logic [7:0]    ram_q, walk_byte;

    // scanner
    logic [CW-1:0]         r_seg_len, r_sep;
    logic [31:0]           r_dec_val;
    logic                  r_dec_ok;
    logic [63:0]           r_hex_val;
    logic                  r_hex_ok;
    logic                  r_model_bad, r_slash_bad, r_vendor_bad;
    logic [FW-1:0]         r_fcnt;
    logic                  r_ovf;
    logic [31:0]           r_type;
    logic                  r_type_ok;
    logic [63:0]           r_elapsed;
    logic                  r_el_ok;
    logic                  r_plat_ok, r_caps_ok, r_f4_ok, r_ver_ok, r_model_ok, r_vendor_ok;
    logic [31:0]           r_seq;
    logic                  r_seq_ok;
    logic                  r_pkt_ok, r_fn_ok, r_seed_ok;
    logic [sfd_pkg::PKT_W-1:0] r_pkt;
    logic [15:0]           r_seed;
    logic [15:0]           r_crc;

    logic        is_bar, dig_dec, dig_hex;
    logic [3:0]  d_dec, d_hex;
    logic [35:0] dec_next;
    logic        dec_good, hex_good, model_ok, vendor_ok;

    logic        req, struct_ok, crc_ok, supported, seq_hit;
    logic [15:0] seed_used;
    sfd_pkg::t_kind fin_kind;
    logic [sfd_pkg::LIM_W-1:0] lim_sum;
    logic [CW-1:0] new_limit;

    // output register
    logic           r_out_vld;
    sfd_pkg::t_kind r_kind;
    logic [31:0]    r_o_type;
    logic [63:0]    r_o_elapsed;
    logic [15:0]    r_o_seed;
    logic [4:0]     r_o_fcnt;
    logic [10:0]    r_o_len;
    logic           r_o_req, r_o_sup, r_o_hseq;
    logic [31:0]    r_o_seq;
    logic           out_free, step_load, load;

    always_comb begin
        n_count     = r_count;
        n_in_frame  = r_in_frame;
        n_discard   = r_discard;
        n_prefix    = r_prefix;
        step_kind   = sfd_pkg::K_NONE;
        ram_we      = 1'b0;
        need_decode = 1'b0;
        count_p2    = {1'b0, r_count} + (CW+1)'(2);
        over        = (count_p2 > {1'b0, r_limit}) || (r_count >= CW'(sfd_pkg::MAX_FRAME_BYTES));
        if (i_opcode == sfd_pkg::OP_END) begin
            step_kind  = (r_in_frame || r_discard) ? sfd_pkg::K_TRUNCATED : sfd_pkg::K_NONE;
            n_count    = '0;
            n_in_frame = 1'b0;
            n_discard  = 1'b0;
            n_prefix   = 2'd0;
        end else if (r_discard) begin
            if (i_data_byte == sfd_pkg::CH_CR) begin
                n_discard = 1'b0;
                n_prefix  = 2'd0;
            end
        end else if (!r_in_frame) begin
            if (i_data_byte == sfd_pkg::lead_chr(r_prefix)) begin
                if (r_prefix == 2'(sfd_pkg::LEAD_LEN - 1)) begin
                    n_count    = CW'(sfd_pkg::LEAD_LEN);
                    n_in_frame = 1'b1;
                    n_prefix   = 2'd0;
                end else begin
                    n_prefix = r_prefix + 2'd1;
                end
            end else begin
                n_prefix = (i_data_byte == sfd_pkg::CH_K) ? 2'd1 : 2'd0;
            end
        end else if (i_data_byte == sfd_pkg::CH_CR) begin
            need_decode = 1'b1;
        end else if (i_data_byte < sfd_pkg::PRINT_LO || i_data_byte > sfd_pkg::PRINT_HI) begin
            n_count    = '0;
            n_in_frame = 1'b0;
            n_discard  = 1'b1;
            step_kind  = sfd_pkg::K_MALFORMED;
        end else if (over) begin
            n_count    = '0;
            n_in_frame = 1'b0;
            n_discard  = 1'b1;
            step_kind  = sfd_pkg::K_TOO_LARGE;
        end else begin
            ram_we  = 1'b1;
            n_count = r_count + CW'(1);
        end
    end

    sfd_ram #(
        .WIDTH(8),
        .DEPTH(sfd_pkg::MAX_FRAME_BYTES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.take && ram_we),
        .i_waddr(r_count[sfd_pkg::ADDR_W-1:0]),
        .i_wdata(i_data_byte),
        .i_raddr(r_ptr[sfd_pkg::ADDR_W-1:0]),
        .o_rdata(ram_q)
    );

    assign issue     = (i_cmd.walk_scan || i_cmd.walk_crc) && (r_ptr < r_end);
    assign walk_byte = (r_pend_idx < CW'(sfd_pkg::LEAD_LEN)) ? sfd_pkg::lead_chr(r_pend_idx[1:0])
                                                            : ram_q;

    always_comb begin
        is_bar    = walk_byte == sfd_pkg::CH_BAR;
        dig_dec   = walk_byte >= 8'h30 && walk_byte <= 8'h39;
        d_dec     = walk_byte[3:0];
        dig_hex   = dig_dec;
        d_hex     = walk_byte[3:0];
        if (walk_byte >= 8'h61 && walk_byte <= 8'h66) begin
            dig_hex = 1'b1;
            d_hex   = 4'(walk_byte - 8'h57);
        end else if (walk_byte >= 8'h41 && walk_byte <= 8'h46) begin
            dig_hex = 1'b1;
            d_hex   = 4'(walk_byte - 8'h37);
        end
        dec_next  = ({4'b0, r_dec_val} << 3) + ({4'b0, r_dec_val} << 1) + {32'b0, d_dec};
        dec_good  = r_dec_ok && (r_seg_len != '0);
        hex_good  = r_hex_ok && (r_seg_len != '0);
        model_ok  = (r_seg_len >= CW'(sfd_pkg::MODEL_LEN)) && !r_model_bad
                    && ((r_seg_len == CW'(sfd_pkg::MODEL_LEN)) || !r_slash_bad);
        vendor_ok = (r_seg_len == CW'(sfd_pkg::VENDOR_LEN)) && !r_vendor_bad;
    end

    always_comb begin
        req       = r_type == sfd_pkg::TYPE_REQ;
        struct_ok = (r_count >= CW'(sfd_pkg::MIN_FRAME)) && (r_fcnt >= FW'(2)) && !r_ovf
                    && (r_seg_len == CW'(sfd_pkg::CRC_DIGITS)) && hex_good
                    && r_type_ok && r_el_ok
                    && (!req || ((r_fcnt == FW'(sfd_pkg::REQ_FIELDS)) && r_seed_ok));
        seed_used = req ? r_seed : (r_hs ? r_sess_seed : 16'h0000);
        crc_ok    = r_crc == r_hex_val[15:0];
        supported = req && r_plat_ok && r_caps_ok && r_ver_ok && r_f4_ok && r_model_ok
                    && r_vendor_ok && r_pkt_ok && r_fn_ok;
        seq_hit   = (r_type == sfd_pkg::TYPE_SEQ_A || r_type == sfd_pkg::TYPE_SEQ_B
                     || r_type == sfd_pkg::TYPE_SEQ_C)
                    && (r_fcnt >= FW'(sfd_pkg::SEQ_FIELDS)) && r_seq_ok;
        if (!struct_ok) begin
            fin_kind = sfd_pkg::K_MALFORMED;
        end else if (!crc_ok) begin
            fin_kind = sfd_pkg::K_CRC_FAILED;
        end else begin
            fin_kind = sfd_pkg::K_FRAME;
        end
        lim_sum   = sfd_pkg::LIM_W'(r_pkt) + sfd_pkg::LIM_W'(sfd_pkg::FRAME_OVERHEAD_BYTES);
        new_limit = (lim_sum > sfd_pkg::MAX_FRAME_BYTES) ? CW'(sfd_pkg::MAX_FRAME_BYTES)
                                                         : CW'(lim_sum);
    end

    assign out_free  = !r_out_vld || !i_out_stall;
    assign step_load = i_cmd.take && !need_decode;
    assign load      = step_load || i_cmd.fin_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_in_frame  <= 1'b0;
            r_discard   <= 1'b0;
            r_prefix    <= 2'd0;
            r_hs        <= 1'b0;
            r_sess_seed <= 16'h0000;
            r_limit     <= sfd_pkg::LIMIT_RST;
        end else if (i_cmd.take) begin
            r_count    <= n_count;
            r_in_frame <= n_in_frame;
            r_discard  <= n_discard;
            r_prefix   <= n_prefix;
            if (i_opcode == sfd_pkg::OP_END) begin
                r_hs        <= 1'b0;
                r_sess_seed <= 16'h0000;
                r_limit     <= sfd_pkg::LIMIT_RST;
            end
        end else if (i_cmd.fin_load) begin
            r_count    <= '0;
            r_in_frame <= 1'b0;
            r_prefix   <= 2'd0;
            if (fin_kind == sfd_pkg::K_FRAME && supported) begin
                r_limit     <= new_limit;
                r_sess_seed <= seed_used;
                r_hs        <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_end      <= '0;
            r_pend     <= 1'b0;
            r_mode_crc <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_ptr      <= CW'(sfd_pkg::LEAD_LEN);
            r_end      <= r_count;
            r_pend     <= 1'b0;
            r_mode_crc <= 1'b0;
        end else if (i_cmd.crc_start) begin
            r_ptr      <= '0;
            r_end      <= r_sep + CW'(1);
            r_pend     <= 1'b0;
            r_mode_crc <= 1'b1;
        end else begin
            r_pend <= issue;
            if (issue) begin
                r_ptr <= r_ptr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_ptr;
        if (i_cmd.scan_start) begin
            r_seg_len    <= '0;
            r_dec_val    <= '0;
            r_dec_ok     <= 1'b1;
            r_hex_val    <= '0;
            r_hex_ok     <= 1'b1;
            r_model_bad  <= 1'b0;
            r_slash_bad  <= 1'b0;
            r_vendor_bad <= 1'b0;
            r_fcnt       <= '0;
            r_ovf        <= 1'b0;
            r_sep        <= '0;
            r_type       <= '0;
            r_type_ok    <= 1'b0;
            r_el_ok      <= 1'b0;
            r_plat_ok    <= 1'b0;
            r_caps_ok    <= 1'b0;
            r_f4_ok      <= 1'b0;
            r_ver_ok     <= 1'b0;
            r_model_ok   <= 1'b0;
            r_vendor_ok  <= 1'b0;
            r_seq_ok     <= 1'b0;
            r_pkt_ok     <= 1'b0;
            r_fn_ok      <= 1'b0;
            r_seed_ok    <= 1'b0;
        end else if (i_cmd.crc_start) begin
            r_crc <= seed_used;
        end else if (r_pend && r_mode_crc) begin
            r_crc <= sfd_pkg::crc_byte(r_crc, walk_byte);
        end else if (r_pend && is_bar) begin
            r_sep        <= r_pend_idx;
            r_seg_len    <= '0;
            r_dec_val    <= '0;
            r_dec_ok     <= 1'b1;
            r_hex_val    <= '0;
            r_hex_ok     <= 1'b1;
            r_model_bad  <= 1'b0;
            r_slash_bad  <= 1'b0;
            r_vendor_bad <= 1'b0;
            if (r_fcnt == FW'(sfd_pkg::FIELD_CAP)) begin
                r_ovf <= 1'b1;
            end else begin
                r_fcnt <= r_fcnt + FW'(1);
                unique case (r_fcnt)
                    sfd_pkg::F_TYPE: begin
                        r_type    <= r_dec_val;
                        r_type_ok <= dec_good;
                    end
                    sfd_pkg::F_ELAPSED: begin
                        r_elapsed <= r_hex_val;
                        r_el_ok   <= hex_good;
                    end
                    sfd_pkg::F_PLAT:   r_plat_ok <= dec_good && (r_dec_val == 32'd1);
                    sfd_pkg::F_CAPS:   r_caps_ok <= dec_good;
                    sfd_pkg::F_IDENT:  r_f4_ok <= r_seg_len == CW'(sfd_pkg::F4_LEN);
                    sfd_pkg::F_VER: begin
                        r_ver_ok <= dec_good && (r_dec_val == 32'd1);
                        r_seq    <= r_dec_val;
                        r_seq_ok <= dec_good;
                    end
                    sfd_pkg::F_MODEL:  r_model_ok <= model_ok;
                    sfd_pkg::F_VENDOR: r_vendor_ok <= vendor_ok;
                    sfd_pkg::F_PKT: begin
                        r_pkt_ok <= dec_good && (r_dec_val != 32'd0)
                                    && (r_dec_val <= sfd_pkg::NEGOTIATED_PACKET_BYTES);
                        r_pkt    <= r_dec_val[sfd_pkg::PKT_W-1:0];
                    end
                    sfd_pkg::F_FN: begin
                        r_fn_ok <= dec_good && (r_dec_val != 32'd0)
                                   && (r_dec_val <= sfd_pkg::FN_MAX);
                    end
                    sfd_pkg::F_SEED: begin
                        r_seed_ok <= hex_good && (r_hex_val[63:16] == 48'd0);
                        r_seed    <= r_hex_val[15:0];
                    end
                    default: ;
                endcase
            end
        end else if (r_pend) begin
            r_seg_len <= r_seg_len + CW'(1);
            r_dec_val <= dec_next[31:0];
            if (!dig_dec || dec_next[35:32] != 4'd0) begin
                r_dec_ok <= 1'b0;
            end
            r_hex_val <= {r_hex_val[59:0], d_hex};
            if (!dig_hex || r_hex_val[63:60] != 4'd0) begin
                r_hex_ok <= 1'b0;
            end
            if (r_seg_len < CW'(sfd_pkg::MODEL_LEN)
                && walk_byte != sfd_pkg::model_chr(r_seg_len[2:0])) begin
                r_model_bad <= 1'b1;
            end
            if (r_seg_len == CW'(sfd_pkg::MODEL_LEN) && walk_byte != sfd_pkg::CH_SLASH) begin
                r_slash_bad <= 1'b1;
            end
            if (r_seg_len < CW'(sfd_pkg::VENDOR_LEN)
                && walk_byte != sfd_pkg::vendor_chr(r_seg_len[3:0])) begin
                r_vendor_bad <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_load) begin
            r_kind      <= step_kind;
            r_o_type    <= '0;
            r_o_elapsed <= '0;
            r_o_seed    <= '0;
            r_o_fcnt    <= '0;
            r_o_len     <= '0;
            r_o_req     <= 1'b0;
            r_o_sup     <= 1'b0;
            r_o_hseq    <= 1'b0;
            r_o_seq     <= '0;
        end else if (i_cmd.fin_load) begin
            r_kind <= fin_kind;
            if (fin_kind == sfd_pkg::K_FRAME) begin
                r_o_type    <= r_type;
                r_o_elapsed <= r_elapsed;
                r_o_seed    <= seed_used;
                r_o_fcnt    <= sfd_pkg::FC_W'(r_fcnt - FW'(2));
                r_o_len     <= sfd_pkg::LEN_W'(r_count + CW'(1));
                r_o_req     <= req;
                r_o_sup     <= supported;
                r_o_hseq    <= seq_hit;
                r_o_seq     <= seq_hit ? r_seq : 32'd0;
            end else begin
                r_o_type    <= '0;
                r_o_elapsed <= '0;
                r_o_seed    <= '0;
                r_o_fcnt    <= '0;
                r_o_len     <= '0;
                r_o_req     <= 1'b0;
                r_o_sup     <= 1'b0;
                r_o_hseq    <= 1'b0;
                r_o_seq     <= '0;
            end
        end
    end

    assign o_sts.need_decode = need_decode;
    assign o_sts.out_free    = out_free;
    assign o_sts.walk_done   = !r_pend && !(r_ptr < r_end);
    assign o_sts.struct_ok   = struct_ok;

    assign o_out_valid             = r_out_vld;
    assign o_event_kind            = r_kind;
    assign o_frame_type            = r_o_type;
    assign o_elapsed_time          = r_o_elapsed;
    assign o_crc_seed_used         = r_o_seed;
    assign o_payload_fields        = r_o_fcnt;
    assign o_frame_length          = r_o_len;
    assign o_is_connection_request = r_o_req;
    assign o_conn_accepted         = r_o_sup;
    assign o_seq_valid             = r_o_hseq;
    assign o_sequence_number       = r_o_seq;

endmodule

[rtl/core/sfd_ctrl.sv]
// Controller of the serial frame decoder: byte intake and the decode sequence.
// Depends on sfd_pkg.
module sfd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  sfd_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output sfd_pkg::t_cmd o_cmd
);

    sfd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            sfd_pkg::S_IDLE: begin
                o_in_stall = !i_sts.out_free;
                o_cmd.take = i_in_valid && i_sts.out_free;
                if (o_cmd.take && i_sts.need_decode) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = sfd_pkg::S_SCAN;
                end
            end
            sfd_pkg::S_SCAN: begin
                o_cmd.walk_scan = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = sfd_pkg::S_EVAL;
                end
            end
            sfd_pkg::S_EVAL: begin
                if (i_sts.struct_ok) begin
                    o_cmd.crc_start = 1'b1;
                    n_state         = sfd_pkg::S_CRC;
                end else begin
                    n_state = sfd_pkg::S_FIN;
                end
            end
            sfd_pkg::S_CRC: begin
                o_cmd.walk_crc = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = sfd_pkg::S_FIN;
                end
            end
            sfd_pkg::S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_state        = sfd_pkg::S_IDLE;
                end
            end
            default: n_state = sfd_pkg::S_IDLE;
        endcase
    end

endmodule
